@@ sv/log_law_wind_profile_assert.svh @@
// assertion macros used by log_law_wind_profile
`ifndef LOG_LAW_WIND_PROFILE_ASSERT_SVH
`define LOG_LAW_WIND_PROFILE_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define LLWP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define LLWP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/llwp_pkg.sv @@
package llwp_pkg;
   localparam int AXIS_FRAC = 14;
   localparam int LN_FRAC   = 30;
   localparam logic [30:0] LN2_Q30 = 31'd744261118;

   localparam logic [2:0] REG_UP_AXIS    = 3'd0;
   localparam logic [2:0] REG_FLOW_DIR   = 3'd1;
   localparam logic [2:0] REG_ROUGH_LEN  = 3'd2;
   localparam logic [2:0] REG_GROUND_HT  = 3'd3;
   localparam logic [2:0] REG_REF_HEIGHT = 3'd4;
   localparam logic [2:0] REG_REF_SPEED  = 3'd5;
   localparam logic [2:0] REG_FRIC_KAPPA = 3'd6;

   typedef logic signed [31:0] q32_type;

   // saturate a wide signed value to 32 bits
   function automatic q32_type sat32(input logic signed [63:0] v);
      q32_type r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = q32_type'(v);
      return r;
   endfunction
endpackage

@@ sv/llwp_norm.sv @@
module llwp_norm
#(
   parameter int W   = 37,
   parameter int LTB = 8
)
(
   input  logic [W-1:0]         x,
   output logic [$clog2(W)-1:0] e,
   output logic [LTB-1:0]       k
);
   logic [W+LTB-1:0] ext;

   // leading one position
   always_comb begin
      e = '0;
      for (int i = 0; i < W; i++) begin
         if (x[i]) e = ($clog2(W))'(i);
      end
   end

   // bits just below the leading one, zero filled
   always_comb begin
      ext = {x, {LTB{1'b0}}} >> e;
      k   = ext[LTB-1:0];
   end
endmodule

@@ sv/llwp_lntab.sv @@
module llwp_lntab
#(
   parameter int LTB = 8
)
(
   input  logic [LTB-1:0] idx_a,
   input  logic [LTB-1:0] idx_b,
   output logic [30:0]    val_a,
   output logic [30:0]    val_b
);
   localparam int TAB = 1 << LTB;

   logic [30:0] tab [TAB];

   // ln(1+k/2^LTB) as 2*atanh series, worked out at elaboration
   for (genvar g = 0; g < TAB; g++) begin : g_ent
      localparam logic [63:0] S  = (64'(g) << 30) / ((64'd2 << LTB) + 64'(g));
      localparam logic [63:0] S2 = (S * S) >> 30;
      localparam logic [63:0] T0  = S;
      localparam logic [63:0] T1  = (T0  * S2) >> 30;
      localparam logic [63:0] T2  = (T1  * S2) >> 30;
      localparam logic [63:0] T3  = (T2  * S2) >> 30;
      localparam logic [63:0] T4  = (T3  * S2) >> 30;
      localparam logic [63:0] T5  = (T4  * S2) >> 30;
      localparam logic [63:0] T6  = (T5  * S2) >> 30;
      localparam logic [63:0] T7  = (T6  * S2) >> 30;
      localparam logic [63:0] T8  = (T7  * S2) >> 30;
      localparam logic [63:0] T9  = (T8  * S2) >> 30;
      localparam logic [63:0] T10 = (T9  * S2) >> 30;
      localparam logic [63:0] T11 = (T10 * S2) >> 30;
      localparam logic [63:0] T12 = (T11 * S2) >> 30;
      localparam logic [63:0] T13 = (T12 * S2) >> 30;
      localparam logic [63:0] T14 = (T13 * S2) >> 30;
      localparam logic [63:0] T15 = (T14 * S2) >> 30;
      localparam logic [63:0] SUM = T0 + T1/3 + T2/5 + T3/7 + T4/9 + T5/11 + T6/13
         + T7/15 + T8/17 + T9/19 + T10/21 + T11/23 + T12/25 + T13/27 + T14/29
         + T15/31;
      localparam logic [63:0] VAL = SUM * 2;
      assign tab[g] = VAL[30:0];
   end

   assign val_a = tab[idx_a];
   assign val_b = tab[idx_b];
endmodule

@@ sv/log_law_wind_profile.sv @@
// log-law inlet wind profile, one face point per transaction
// throughput: one transaction per cycle; the whole pipeline holds while rsp is stalled
// reset (synchronous, active high) clears the stage valid bits and loads the
// configuration registers with their default values
module log_law_wind_profile
   import llwp_pkg::*;
#(
   parameter int FRAC_BITS      = 16,
   parameter int LOG_TABLE_BITS = 8
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // point_x, point_y, point_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // vel_x, vel_y, vel_z, speed
   output logic [1:0]   rsp_tuser,   // in_log_region, invalid
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [47:0]  csr_wdata
);
   localparam int LTB     = LOG_TABLE_BITS;
   // smallest divisor, 0.001 m rounded, never below one lsb
   localparam int MR_RAW  = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int MIN_RGH = (MR_RAW < 1) ? 1 : MR_RAW;
   localparam int LQ_SH   = LN_FRAC - FRAC_BITS;
   localparam int LQW     = 39 - LQ_SH;
   localparam int NEW     = $clog2(37);
   localparam int DEW     = $clog2(31);

   // configuration registers
   logic [47:0]        up_axis_ff,  up_axis_in;
   logic [47:0]        flow_dir_ff, flow_dir_in;
   logic [30:0]        rough_ff,    rough_in;
   logic signed [31:0] ground_ff,   ground_in;
   logic [30:0]        ref_ht_ff,   ref_ht_in;
   logic signed [31:0] ref_spd_ff,  ref_spd_in;
   logic [30:0]        fok_ff,      fok_in;

   always_comb begin
      up_axis_in  = up_axis_ff;
      flow_dir_in = flow_dir_ff;
      rough_in    = rough_ff;
      ground_in   = ground_ff;
      ref_ht_in   = ref_ht_ff;
      ref_spd_in  = ref_spd_ff;
      fok_in      = fok_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_UP_AXIS:    up_axis_in  = csr_wdata;
            REG_FLOW_DIR:   flow_dir_in = csr_wdata;
            REG_ROUGH_LEN:  rough_in    = csr_wdata[30:0];
            REG_GROUND_HT:  ground_in   = csr_wdata[31:0];
            REG_REF_HEIGHT: ref_ht_in   = csr_wdata[30:0];
            REG_REF_SPEED:  ref_spd_in  = csr_wdata[31:0];
            REG_FRIC_KAPPA: fok_in      = csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_axis_ff  <= 48'd16384;
         flow_dir_ff <= 48'd1073741824;
         rough_ff    <= 31'd6554;
         ground_ff   <= '0;
         ref_ht_ff   <= 31'd655360;
         ref_spd_ff  <= 32'sd655360;
         fok_ff      <= 31'd65536;
      end else begin
         up_axis_ff  <= up_axis_in;
         flow_dir_ff <= flow_dir_in;
         rough_ff    <= rough_in;
         ground_ff   <= ground_in;
         ref_ht_ff   <= ref_ht_in;
         ref_spd_ff  <= ref_spd_in;
         fok_ff      <= fok_in;
      end
   end

   // whole pipeline advances together unless the output register is stuck
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // stage valid bits, stage 8 is the output register
   logic [8:1] vld_ff, vld_in;
   assign vld_in = {vld_ff[7:1], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // stage 1: projection products onto the up axis
   logic signed [47:0] p1_ff [3], p1_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_in[i] = 48'($signed(req_tdata[32*i +: 32])) * 48'($signed(up_axis_ff[16*i +: 16]));
      end
   end

   // stage 2: height above ground, region test, log argument
   logic signed [49:0] sum2;
   logic signed [36:0] h2;
   logic signed [37:0] num2_in, num2_ff;
   logic               log2_in, log2_ff, bad2_in, bad2_ff;
   always_comb begin
      sum2    = 50'(p1_ff[0]) + 50'(p1_ff[1]) + 50'(p1_ff[2]);
      h2      = 37'(sum2 >>> AXIS_FRAC) - 37'(ground_ff);
      num2_in = 38'(h2) + $signed({7'd0, rough_ff});
      log2_in = h2 < $signed({6'd0, ref_ht_ff});
      bad2_in = log2_in && (num2_in <= 38'sd0);
   end

   // stage 3: normalisation of numerator, clamped divisor from configuration
   logic [30:0]     den;
   logic [NEW-1:0]  en3_in, en3_ff;
   logic [LTB-1:0]  kn3_in, kn3_ff, kd3_in, kd3_ff;
   logic [DEW-1:0]  ed3_in, ed3_ff;
   logic            log3_ff, bad3_ff;
   assign den = (rough_ff > 31'(MIN_RGH)) ? rough_ff : 31'(MIN_RGH);

   llwp_norm #(.W(37), .LTB(LTB)) u_norm_num (
      .x (num2_ff[36:0]),
      .e (en3_in),
      .k (kn3_in)
   );
   llwp_norm #(.W(31), .LTB(LTB)) u_norm_den (
      .x (den),
      .e (ed3_in),
      .k (kd3_in)
   );

   // stage 4: log difference in Q9.30
   logic [30:0]        tn4, td4;
   logic signed [6:0]  ediff;
   logic signed [38:0] l4_in, l4_ff;
   logic               log4_ff, bad4_ff;
   llwp_lntab #(.LTB(LTB)) u_lntab (
      .idx_a (kn3_ff),
      .idx_b (kd3_ff),
      .val_a (tn4),
      .val_b (td4)
   );
   always_comb begin
      ediff = $signed({1'b0, 6'(en3_ff)}) - $signed({1'b0, 6'(ed3_ff)});
      l4_in = 39'(ediff) * $signed({8'd0, LN2_Q30})
            + $signed({8'd0, tn4}) - $signed({8'd0, td4});
   end

   // stage 5: scale by friction velocity over kappa
   logic signed [LQW-1:0]    lq5;
   logic signed [LQW+31:0]   m5_in, m5_ff;
   logic                     log5_ff, bad5_ff;
   always_comb begin
      lq5   = LQW'(l4_ff >>> LQ_SH);
      m5_in = (LQW+32)'($signed({1'b0, fok_ff})) * (LQW+32)'(lq5);
   end

   // stage 6: speed selection
   logic signed [31:0] spd6_in, spd6_ff;
   logic               log6_ff, bad6_ff;
   always_comb begin
      if (!log5_ff) spd6_in = ref_spd_ff;
      else if (bad5_ff) spd6_in = '0;
      else spd6_in = sat32(64'(m5_ff >>> FRAC_BITS));
   end

   // stage 7: direction products
   logic signed [47:0] d7_in [3], d7_ff [3];
   logic signed [31:0] spd7_ff;
   logic               log7_ff, bad7_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d7_in[i] = 48'(spd6_ff) * 48'($signed(flow_dir_ff[16*i +: 16]));
      end
   end

   // stage 8: output register with saturation
   logic signed [31:0] vel8_in [3], vel8_ff [3];
   logic signed [31:0] spd8_ff;
   logic               log8_ff, bad8_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel8_in[i] = sat32(64'(d7_ff[i] >>> AXIS_FRAC));
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= p1_in;
         num2_ff <= num2_in;
         log2_ff <= log2_in;
         bad2_ff <= bad2_in;
         en3_ff  <= en3_in;
         kn3_ff  <= kn3_in;
         ed3_ff  <= ed3_in;
         kd3_ff  <= kd3_in;
         log3_ff <= log2_ff;
         bad3_ff <= bad2_ff;
         l4_ff   <= l4_in;
         log4_ff <= log3_ff;
         bad4_ff <= bad3_ff;
         m5_ff   <= m5_in;
         log5_ff <= log4_ff;
         bad5_ff <= bad4_ff;
         spd6_ff <= spd6_in;
         log6_ff <= log5_ff;
         bad6_ff <= bad5_ff;
         d7_ff   <= d7_in;
         spd7_ff <= spd6_ff;
         log7_ff <= log6_ff;
         bad7_ff <= bad6_ff;
         vel8_ff <= vel8_in;
         spd8_ff <= spd7_ff;
         log8_ff <= log7_ff;
         bad8_ff <= bad7_ff;
      end
   end

   assign rsp_tvalid = vld_ff[8];
   assign rsp_tdata  = {spd8_ff, vel8_ff[2], vel8_ff[1], vel8_ff[0]};
   assign rsp_tuser  = {bad8_ff, log8_ff};

`include "log_law_wind_profile_assert.svh"

   // an invalid log argument only arises inside the log region, with zero speed
   `LLWP_ASSERT_IMP(a_bad_in_log, rsp_tvalid && bad8_ff, log8_ff && spd8_ff == 32'sd0, "invalid outside log region or nonzero speed")
   // an accepted transaction always reaches stage one
   `LLWP_ASSERT_NXT(a_enter, req_tvalid && req_tready, vld_ff[1], "accepted transaction lost")
   // invalid flag set only where the numerator is not positive
   `LLWP_ASSERT_IMP(a_bad_num, vld_ff[2] && bad2_ff, log2_ff && num2_ff <= 38'sd0, "invalid flag without bad numerator")
endmodule
